// ===== sv/array_list_insert_delete_search_top_macros.svh =====
`ifndef ARRAY_LIST_INSERT_DELETE_SEARCH_TOP_MACROS_SVH
`define ARRAY_LIST_INSERT_DELETE_SEARCH_TOP_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define ALIDS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("alids check failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define ALIDS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("alids check failed");

`endif

// ===== sv/alids_pkg.sv =====
`default_nettype none

package alids_pkg;

  // default list capacity
  localparam int unsigned CAPACITY_DEF = 64;

  localparam int unsigned DATA_W = 32;

  typedef enum logic [1:0] {
    A_INSERT  = 2'd0,
    A_DEL_POS = 2'd1,
    A_DEL_VAL = 2'd2,
    A_SEARCH  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_FULL     = 2'd1,
    ST_RANGE    = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  // sequencer steps
  typedef enum logic [4:0] {
    S_IDLE,
    S_INS_FULL,
    S_INS_RNG,
    S_INS_TEST,
    S_INS_PRIME,
    S_INS_LOOP,
    S_INS_WR,
    S_DEL_RNG,
    S_DEL_START,
    S_DEL_PRIME,
    S_DEL_LOOP,
    S_DEC_CNT,
    S_SCAN_INIT,
    S_SCAN_PRIME,
    S_SCAN_LOOP,
    S_SCAN_HIT,
    S_RESP
  } step_t;

  // branch conditions
  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_IN_VALID,
    C_FULL,
    C_POS_GT_CNT,
    C_POS_GE_CNT,
    C_PTR_EQ_POS,
    C_PTR_M1_EQ_POS,
    C_PTR_P1_EQ_CNT,
    C_PTR_P2_EQ_CNT,
    C_CNT_ZERO,
    C_MATCH,
    C_SEARCH,
    C_OUT_FREE
  } cond_t;

  typedef enum logic [1:0] {
    SS_NONE,
    SS_ON_A,
    SS_ON_B
  } st_sel_t;

  typedef enum logic [2:0] {
    P_HOLD,
    P_LOAD_COUNT,
    P_LOAD_POS,
    P_LOAD_ZERO,
    P_LOAD_FOUND,
    P_INC,
    P_DEC
  } ptr_op_t;

  typedef enum logic [2:0] {
    RA_PTR,
    RA_PTR_M1,
    RA_PTR_M2,
    RA_PTR_P1,
    RA_PTR_P2
  } ra_sel_t;

  typedef enum logic {
    WA_PTR,
    WA_POS
  } wa_sel_t;

  typedef enum logic {
    WD_RDATA,
    WD_VALUE
  } wd_sel_t;

  typedef enum logic [1:0] {
    K_HOLD,
    K_INC,
    K_DEC
  } cnt_op_t;

  // one control word of the microprogram
  typedef struct packed {
    cond_t   cond_a;
    step_t   tgt_a;
    logic    disp_a;
    cond_t   cond_b;
    step_t   tgt_b;
    step_t   tgt_n;
    st_sel_t st_sel;
    status_t st_val;
    logic    found_ld;
    ptr_op_t ptr_op;
    ra_sel_t ra_sel;
    logic    ram_we;
    wa_sel_t wa_sel;
    wd_sel_t wd_sel;
    cnt_op_t cnt_op;
    logic    out_ld;
    logic    in_rdy;
  } cw_t;

  // which branch the sequencer took this cycle
  typedef struct packed {
    logic a;
    logic b;
  } br_t;

  // datapath status seen by the sequencer
  typedef struct packed {
    logic    in_valid;
    action_t act;
    logic    full;
    logic    pos_gt_cnt;
    logic    pos_ge_cnt;
    logic    ptr_eq_pos;
    logic    ptr_m1_eq_pos;
    logic    ptr_p1_eq_cnt;
    logic    ptr_p2_eq_cnt;
    logic    cnt_zero;
    logic    match;
    logic    search;
    logic    out_free;
  } flags_t;

  localparam cw_t CW_NOP = '{
    cond_a: C_NEVER, tgt_a: S_IDLE, disp_a: 1'b0,
    cond_b: C_NEVER, tgt_b: S_IDLE, tgt_n: S_IDLE,
    st_sel: SS_NONE, st_val: ST_DONE, found_ld: 1'b0,
    ptr_op: P_HOLD, ra_sel: RA_PTR, ram_we: 1'b0,
    wa_sel: WA_PTR, wd_sel: WD_RDATA, cnt_op: K_HOLD,
    out_ld: 1'b0, in_rdy: 1'b0
  };

  // first step of each action
  function automatic step_t dispatch(input action_t a);
    step_t s;
    case (a)
      A_INSERT:  s = S_INS_FULL;
      A_DEL_POS: s = S_DEL_RNG;
      A_DEL_VAL: s = S_SCAN_INIT;
      A_SEARCH:  s = S_SCAN_INIT;
      default:   s = S_IDLE;
    endcase
    return s;
  endfunction

  // microprogram rom
  function automatic cw_t ucode(input step_t s);
    cw_t c;
    c = CW_NOP;
    case (s)
      S_IDLE: begin
        c.in_rdy = 1'b1;
        c.cond_a = C_IN_VALID;
        c.disp_a = 1'b1;
        c.tgt_n  = S_IDLE;
      end
      // insert: refuse when full or past the end
      S_INS_FULL: begin
        c.cond_a = C_FULL;
        c.tgt_a  = S_RESP;
        c.st_sel = SS_ON_A;
        c.st_val = ST_FULL;
        c.tgt_n  = S_INS_RNG;
      end
      S_INS_RNG: begin
        c.cond_a = C_POS_GT_CNT;
        c.tgt_a  = S_RESP;
        c.st_sel = SS_ON_A;
        c.st_val = ST_RANGE;
        c.ptr_op = P_LOAD_COUNT;
        c.tgt_n  = S_INS_TEST;
      end
      S_INS_TEST: begin
        c.cond_a = C_PTR_EQ_POS;
        c.tgt_a  = S_INS_WR;
        c.tgt_n  = S_INS_PRIME;
      end
      S_INS_PRIME: begin
        c.ra_sel = RA_PTR_M1;
        c.tgt_n  = S_INS_LOOP;
      end
      // move one entry up per cycle, top down
      S_INS_LOOP: begin
        c.ram_we = 1'b1;
        c.wa_sel = WA_PTR;
        c.wd_sel = WD_RDATA;
        c.ra_sel = RA_PTR_M2;
        c.ptr_op = P_DEC;
        c.cond_a = C_PTR_M1_EQ_POS;
        c.tgt_a  = S_INS_WR;
        c.tgt_n  = S_INS_LOOP;
      end
      S_INS_WR: begin
        c.ram_we = 1'b1;
        c.wa_sel = WA_POS;
        c.wd_sel = WD_VALUE;
        c.cnt_op = K_INC;
        c.tgt_n  = S_RESP;
      end
      // delete at index
      S_DEL_RNG: begin
        c.cond_a = C_POS_GE_CNT;
        c.tgt_a  = S_RESP;
        c.st_sel = SS_ON_A;
        c.st_val = ST_RANGE;
        c.ptr_op = P_LOAD_POS;
        c.tgt_n  = S_DEL_START;
      end
      S_DEL_START: begin
        c.cond_a = C_PTR_P1_EQ_CNT;
        c.tgt_a  = S_DEC_CNT;
        c.tgt_n  = S_DEL_PRIME;
      end
      S_DEL_PRIME: begin
        c.ra_sel = RA_PTR_P1;
        c.tgt_n  = S_DEL_LOOP;
      end
      // move one entry down per cycle, bottom up
      S_DEL_LOOP: begin
        c.ram_we = 1'b1;
        c.wa_sel = WA_PTR;
        c.wd_sel = WD_RDATA;
        c.ra_sel = RA_PTR_P2;
        c.ptr_op = P_INC;
        c.cond_a = C_PTR_P2_EQ_CNT;
        c.tgt_a  = S_DEC_CNT;
        c.tgt_n  = S_DEL_LOOP;
      end
      S_DEC_CNT: begin
        c.cnt_op = K_DEC;
        c.tgt_n  = S_RESP;
      end
      // linear scan for the first match
      S_SCAN_INIT: begin
        c.ptr_op = P_LOAD_ZERO;
        c.cond_a = C_CNT_ZERO;
        c.tgt_a  = S_RESP;
        c.st_sel = SS_ON_A;
        c.st_val = ST_NOTFOUND;
        c.tgt_n  = S_SCAN_PRIME;
      end
      S_SCAN_PRIME: begin
        c.ra_sel = RA_PTR;
        c.tgt_n  = S_SCAN_LOOP;
      end
      S_SCAN_LOOP: begin
        c.ra_sel   = RA_PTR_P1;
        c.ptr_op   = P_INC;
        c.cond_a   = C_MATCH;
        c.tgt_a    = S_SCAN_HIT;
        c.found_ld = 1'b1;
        c.cond_b   = C_PTR_P1_EQ_CNT;
        c.tgt_b    = S_RESP;
        c.st_sel   = SS_ON_B;
        c.st_val   = ST_NOTFOUND;
        c.tgt_n    = S_SCAN_LOOP;
      end
      S_SCAN_HIT: begin
        c.ptr_op = P_LOAD_FOUND;
        c.cond_a = C_SEARCH;
        c.tgt_a  = S_RESP;
        c.tgt_n  = S_DEL_START;
      end
      // hand the result to the output register
      S_RESP: begin
        c.cond_a = C_OUT_FREE;
        c.tgt_a  = S_IDLE;
        c.out_ld = 1'b1;
        c.tgt_n  = S_RESP;
      end
      default: c.tgt_n = S_IDLE;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== sv/alids_ram.sv =====
`default_nettype none

module alids_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== sv/alids_seq.sv =====
`default_nettype none

module alids_seq
  import alids_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire flags_t flags,
  output cw_t         cw,
  output br_t         br
);

  step_t step_r, step_nxt;

  function automatic logic cond_true(input cond_t c, input flags_t f);
    logic t;
    case (c)
      C_NEVER:         t = 1'b0;
      C_ALWAYS:        t = 1'b1;
      C_IN_VALID:      t = f.in_valid;
      C_FULL:          t = f.full;
      C_POS_GT_CNT:    t = f.pos_gt_cnt;
      C_POS_GE_CNT:    t = f.pos_ge_cnt;
      C_PTR_EQ_POS:    t = f.ptr_eq_pos;
      C_PTR_M1_EQ_POS: t = f.ptr_m1_eq_pos;
      C_PTR_P1_EQ_CNT: t = f.ptr_p1_eq_cnt;
      C_PTR_P2_EQ_CNT: t = f.ptr_p2_eq_cnt;
      C_CNT_ZERO:      t = f.cnt_zero;
      C_MATCH:         t = f.match;
      C_SEARCH:        t = f.search;
      C_OUT_FREE:      t = f.out_free;
      default:         t = 1'b0;
    endcase
    return t;
  endfunction

  // step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= S_IDLE;
    end else begin
      step_r <= step_nxt;
    end
  end

  // control word lookup and two-way conditional jump
  always_comb begin
    cw   = ucode(step_r);
    br.a = cond_true(cw.cond_a, flags);
    br.b = !br.a && cond_true(cw.cond_b, flags);
    if (br.a) begin
      step_nxt = cw.disp_a ? dispatch(flags.act) : cw.tgt_a;
    end else if (br.b) begin
      step_nxt = cw.tgt_b;
    end else begin
      step_nxt = cw.tgt_n;
    end
  end

endmodule

`default_nettype wire

// ===== sv/alids_dp.sv =====
`default_nettype none

module alids_dp
  import alids_pkg::*;
#(
  parameter int unsigned CAPACITY = CAPACITY_DEF,
  localparam int unsigned AW = $clog2(CAPACITY)
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire cw_t                cw,
  input  wire br_t                br,
  output flags_t                  flags,
  // request channel
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         in_action,
  input  wire logic [6:0]         in_position,
  input  wire logic signed [31:0] in_item_value,
  // result channel
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [1:0]              out_status,
  output logic [5:0]              out_found_position,
  output logic [6:0]              out_entry_count,
  // list memory
  output logic                    ram_we,
  output logic [AW-1:0]           ram_waddr,
  output logic [DATA_W-1:0]       ram_wdata,
  output logic [AW-1:0]           ram_raddr,
  input  wire logic [DATA_W-1:0]  ram_rdata
);

  localparam int unsigned CW   = $clog2(CAPACITY + 1);
  localparam int unsigned CMPW = (CW > 7) ? CW : 7;
  localparam int unsigned PW   = CMPW + 1;
  localparam int unsigned FW   = (AW > 6) ? AW : 6;

  action_t            act_r, act_nxt;
  logic [6:0]         pos_r, pos_nxt;
  logic signed [31:0] val_r, val_nxt;
  status_t            status_r, status_nxt;
  logic [AW-1:0]      found_r, found_nxt;
  logic [CW-1:0]      ptr_r, ptr_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic               out_valid_r, out_valid_nxt;
  status_t            out_status_r, out_status_nxt;
  logic [5:0]         out_found_r, out_found_nxt;
  logic [6:0]         out_count_r, out_count_nxt;

  logic          in_acc, out_free, out_load;
  logic [PW-1:0] ptr_w, cnt_w, pos_w, cap_w, ra_w, wa_w;
  logic [FW-1:0] found_ext;

  assign ptr_w = PW'(ptr_r);
  assign cnt_w = PW'(count_r);
  assign pos_w = PW'(pos_r);
  assign cap_w = PW'(CAPACITY);

  assign in_ready = cw.in_rdy;
  assign in_acc   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign out_load = cw.out_ld && br.a;

  // status flags for the sequencer
  always_comb begin
    flags.in_valid      = in_valid;
    flags.act           = action_t'(in_action);
    flags.full          = cnt_w >= cap_w;
    flags.pos_gt_cnt    = pos_w > cnt_w;
    flags.pos_ge_cnt    = pos_w >= cnt_w;
    flags.ptr_eq_pos    = ptr_w == pos_w;
    flags.ptr_m1_eq_pos = (ptr_w - PW'(1)) == pos_w;
    flags.ptr_p1_eq_cnt = (ptr_w + PW'(1)) == cnt_w;
    flags.ptr_p2_eq_cnt = (ptr_w + PW'(2)) == cnt_w;
    flags.cnt_zero      = count_r == '0;
    flags.match         = ram_rdata == val_r;
    flags.search        = act_r == A_SEARCH;
    flags.out_free      = out_free;
  end

  // memory address and data select
  always_comb begin
    case (cw.ra_sel)
      RA_PTR:    ra_w = ptr_w;
      RA_PTR_M1: ra_w = ptr_w - PW'(1);
      RA_PTR_M2: ra_w = ptr_w - PW'(2);
      RA_PTR_P1: ra_w = ptr_w + PW'(1);
      RA_PTR_P2: ra_w = ptr_w + PW'(2);
      default:   ra_w = ptr_w;
    endcase
    wa_w      = (cw.wa_sel == WA_POS) ? pos_w : ptr_w;
    ram_raddr = ra_w[AW-1:0];
    ram_waddr = wa_w[AW-1:0];
    ram_we    = cw.ram_we;
    ram_wdata = (cw.wd_sel == WD_VALUE) ? DATA_W'(val_r) : ram_rdata;
  end

  // next values of the working registers
  always_comb begin
    act_nxt    = act_r;
    pos_nxt    = pos_r;
    val_nxt    = val_r;
    status_nxt = status_r;
    found_nxt  = found_r;
    ptr_nxt    = ptr_r;
    count_nxt  = count_r;

    // latch the request
    if (in_acc) begin
      act_nxt    = action_t'(in_action);
      pos_nxt    = in_position;
      val_nxt    = in_item_value;
      status_nxt = ST_DONE;
      found_nxt  = '0;
    end

    // status on the branch the step names
    if ((cw.st_sel == SS_ON_A && br.a) || (cw.st_sel == SS_ON_B && br.b)) begin
      status_nxt = cw.st_val;
    end
    if (cw.found_ld && br.a) begin
      found_nxt = ptr_r[AW-1:0];
    end

    // walk pointer
    case (cw.ptr_op)
      P_HOLD:       ptr_nxt = ptr_r;
      P_LOAD_COUNT: ptr_nxt = count_r;
      P_LOAD_POS:   ptr_nxt = pos_w[CW-1:0];
      P_LOAD_ZERO:  ptr_nxt = '0;
      P_LOAD_FOUND: ptr_nxt = CW'(found_r);
      P_INC:        ptr_nxt = ptr_r + CW'(1);
      P_DEC:        ptr_nxt = ptr_r - CW'(1);
      default:      ptr_nxt = ptr_r;
    endcase

    // entry count
    case (cw.cnt_op)
      K_HOLD:  count_nxt = count_r;
      K_INC:   count_nxt = count_r + CW'(1);
      K_DEC:   count_nxt = count_r - CW'(1);
      default: count_nxt = count_r;
    endcase
  end

  // output register
  always_comb begin
    found_ext      = FW'(found_r);
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_found_nxt  = out_found_r;
    out_count_nxt  = out_count_r;
    if (out_load) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = status_r;
      out_found_nxt  = found_ext[5:0];
      out_count_nxt  = cnt_w[6:0];
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    act_r        <= act_nxt;
    pos_r        <= pos_nxt;
    val_r        <= val_nxt;
    status_r     <= status_nxt;
    found_r      <= found_nxt;
    ptr_r        <= ptr_nxt;
    out_status_r <= out_status_nxt;
    out_found_r  <= out_found_nxt;
    out_count_r  <= out_count_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_found_position = out_found_r;
  assign out_entry_count    = out_count_r;

endmodule

`default_nettype wire

// ===== sv/array_list_insert_delete_search_top.sv =====
`default_nettype none

// Ordered list of up to CAPACITY signed 32-bit values held in a single-port-write,
// registered-read RAM, run by a small microprogram. One request is worked at a
// time; a request is taken only while the sequencer sits idle, which it may do
// while the previous result still waits in the output register. Each request
// moves or compares one RAM entry per cycle, so the time is set by that one
// read and one write port. Insert and delete at index move the entries from
// the position to the end of the list, search scans up from index 0 to the
// first match, and delete by value scans and then moves the entries above the
// match; a refused request goes straight to the result. The next request can be
// taken in the cycle after the result is loaded; a stalled result stops the
// sequencer once the following request has reached its result. List contents
// need no clearing after reset: only entries below the count affect a result.
module array_list_insert_delete_search_top
  import alids_pkg::*;
#(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         in_action,
  input  wire logic [6:0]         in_position,
  input  wire logic signed [31:0] in_item_value,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [1:0]              out_status,
  output logic [5:0]              out_found_position,
  output logic [6:0]              out_entry_count
);

  localparam int unsigned AW = $clog2(CAPACITY);

  cw_t               cw;
  br_t               br;
  flags_t            flags;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [DATA_W-1:0] ram_wdata, ram_rdata;

  // microprogram sequencer
  alids_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .flags (flags),
    .cw    (cw),
    .br    (br)
  );

  // registers, compare and address datapath
  alids_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cw                 (cw),
    .br                 (br),
    .flags              (flags),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_action          (in_action),
    .in_position        (in_position),
    .in_item_value      (in_item_value),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_status         (out_status),
    .out_found_position (out_found_position),
    .out_entry_count    (out_entry_count),
    .ram_we             (ram_we),
    .ram_waddr          (ram_waddr),
    .ram_wdata          (ram_wdata),
    .ram_raddr          (ram_raddr),
    .ram_rdata          (ram_rdata)
  );

  // list storage
  alids_ram #(
    .WIDTH (DATA_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

`default_nettype wire

// ===== sv/alids_checker.sv =====
`default_nettype none

`include "array_list_insert_delete_search_top_macros.svh"

module alids_checker
  import alids_pkg::*;
#(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [1:0] out_status,
  input wire logic [5:0] out_found_position,
  input wire logic [6:0] out_entry_count
);

  // one request at a time: a taken request closes the input
  `ALIDS_ASSERT_NXT(a_req_closes, in_valid && in_ready, !in_ready)

  // a stalled result holds
  `ALIDS_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_status) && $stable(out_found_position) && $stable(out_entry_count))

  // a full refusal reports a full list
  `ALIDS_ASSERT_IMP(a_full_count, out_valid && out_status == ST_FULL, out_entry_count == 7'(CAPACITY))

  // a found index only comes with a completed request
  `ALIDS_ASSERT_IMP(a_found_done, out_valid && out_found_position != 6'd0, out_status == ST_DONE)

endmodule

bind array_list_insert_delete_search_top alids_checker #(
  .CAPACITY (CAPACITY)
) u_alids_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_ready           (in_ready),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_status         (out_status),
  .out_found_position (out_found_position),
  .out_entry_count    (out_entry_count)
);

`default_nettype wire
